// File: rtl/ffha_pkg.sv
// Shared constants, codes and types of the first-fit heap allocator.
package ffha_pkg;

  localparam int MAX_CHUNKS    = 64;
  // Alignment of user addresses; must be a power of two.
  localparam int ALIGN_BYTES_P = 16;
  localparam int HEADER_BYTES  = 24;
  localparam int ADDR_BITS     = 32;

  localparam int WORD_W = 32;
  localparam int IDX_W  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
  localparam int CFG_IDX_W = 1;

  localparam logic [WORD_W-1:0] ADDR_MASK =
    (ADDR_BITS >= WORD_W) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [WORD_W:0] ALIGN_MASK = (WORD_W+1)'(ALIGN_BYTES_P - 1);
  localparam logic [WORD_W:0] HEADER_W   = (WORD_W+1)'(HEADER_BYTES);
  localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_CHUNKS);

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_END   = 1'b1;

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_RESIZE  = 2'd2,
    REQ_ARRAY   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_FULL      = 3'd3,
    ST_DOUBLE    = 3'd4,
    ST_UNKNOWN   = 3'd5
  } status_t;

  typedef struct packed {
    logic [WORD_W-1:0] user_addr;
    logic [WORD_W-1:0] size;
    logic              free;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: rtl/ffha_table.sv
// Chunk table memory: one write port, one registered read port.
module ffha_table (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ffha_pkg::IDX_W-1:0] waddr,
  input  ffha_pkg::entry_t           wdata,
  input  logic [ffha_pkg::IDX_W-1:0] raddr,
  output ffha_pkg::entry_t           rdata
);

  ffha_pkg::entry_t mem [ffha_pkg::MAX_CHUNKS];
  ffha_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/ffha_mul.sv
// Registered 32 x 32 multiplier for the array size product.
module ffha_mul (
  input  logic                          clk,
  input  logic                          start,
  input  logic [ffha_pkg::WORD_W-1:0]   a,
  input  logic [ffha_pkg::WORD_W-1:0]   b,
  output logic [2*ffha_pkg::WORD_W-1:0] prod
);

  logic [2*ffha_pkg::WORD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= {{ffha_pkg::WORD_W{1'b0}}, a} * {{ffha_pkg::WORD_W{1'b0}}, b};
    end
  end

  assign prod = prod_r;

endmodule

// File: rtl/ffha_cmp.sv
// Scan compare unit: first-fit test or address lookup against one table entry.
module ffha_cmp (
  input  logic                        find_mode,
  input  ffha_pkg::entry_t            ent,
  input  logic [ffha_pkg::WORD_W-1:0] key_addr,
  input  logic [ffha_pkg::WORD_W-1:0] key_size,
  output logic                        hit
);

  always_comb begin
    if (find_mode) begin
      hit = (ent.user_addr == key_addr);
    end else begin
      hit = ent.free && (ent.size >= key_size);
    end
  end

endmodule

// File: rtl/first_fit_heap_allocator.sv
// First-fit heap allocator: request sequencer, break logic and output register.
//
// Requests enter on in_valid/in_stall and are accepted when in_valid is high
// and in_stall is low. One request is worked on at a time: in_stall stays high
// from acceptance until the result is loaded into the output register. Results
// leave on out_valid/out_stall; the output register lets the next request be
// accepted while the previous result still waits on a stalled receiver, and a
// finished request waits in its last state while that register is still full.
// The scan reads the table once per cycle through the single read port, one
// entry of the N in use at a time. Allocate or release runs one scan; growing
// the heap adds a break check and a table write. Allocate array first forms
// the product. A resize that moves the block runs a lookup scan and then an
// allocate scan. Null release and zero size finish without a scan.
// The next request is accepted once a result is loaded and the block is idle.
// Configuration (cfg_we, cfg_index, cfg_wdata) is to be written only while
// idle; the block itself does not enforce it. Writing heap_start sets the
// break, and only while the table is empty.
// Reset (rst_n low, synchronous) empties the table, sets the break to 0 and
// heap_end to all ones, and drops out_valid. No clearing pass is needed.
module first_fit_heap_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ffha_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ffha_pkg::WORD_W-1:0]    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_req_type,
  input  logic [ffha_pkg::WORD_W-1:0]    in_block_address,
  input  logic [ffha_pkg::WORD_W-1:0]    in_request_size,
  input  logic [ffha_pkg::WORD_W-1:0]    in_element_count,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_status,
  output logic [ffha_pkg::WORD_W-1:0]    out_result_address,
  output logic [ffha_pkg::WORD_W-1:0]    out_prior_address,
  output logic [ffha_pkg::WORD_W-1:0]    out_prior_size
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_SCAN,
    S_GROW1,
    S_GROW2,
    S_FREE_OLD,
    S_DONE
  } state_t;

  localparam int W = ffha_pkg::WORD_W;

  state_t                     state_r;
  ffha_pkg::req_t             req_r;
  logic [W-1:0]               addr_r;
  logic [W-1:0]               size_r;
  logic [W-1:0]               elem_r;
  ffha_pkg::status_t          st_r;
  logic [W-1:0]               res_r;
  logic [W-1:0]               paddr_r;
  logic [W-1:0]               psize_r;
  logic                       find_mode_r;
  logic                       move_r;
  logic [ffha_pkg::IDX_W-1:0] old_idx_r;
  logic [W-1:0]               old_size_r;
  logic [ffha_pkg::CNT_W-1:0] issue_r;
  logic [ffha_pkg::IDX_W-1:0] chk_r;
  logic                       pend_r;
  logic [W:0]                 first_r;
  logic [W-1:0]               rem_r;
  logic [ffha_pkg::CNT_W-1:0] count_r;
  logic [W-1:0]               break_r;
  logic [W-1:0]               end_r;

  logic                       out_valid_r;
  ffha_pkg::status_t          out_status_r;
  logic [W-1:0]               out_res_r;
  logic [W-1:0]               out_paddr_r;
  logic [W-1:0]               out_psize_r;

  logic                       tbl_we;
  logic [ffha_pkg::IDX_W-1:0] tbl_waddr;
  ffha_pkg::entry_t           tbl_wdata;
  ffha_pkg::entry_t           rd_ent;
  logic                       hit;
  logic                       mul_start;
  logic [2*W-1:0]             prod;

  logic [W-1:0]               limit;
  logic [W:0]                 rem_w;
  logic [W:0]                 pad_w;
  logic [W+1:0]               need_w;
  logic                       grow_fit;
  logic [W:0]                 new_addr_w;
  logic                       in_accept;
  logic                       out_free;

  ffha_table u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (issue_r[ffha_pkg::IDX_W-1:0]),
    .rdata (rd_ent)
  );

  ffha_cmp u_cmp (
    .find_mode (find_mode_r),
    .ent       (rd_ent),
    .key_addr  (addr_r),
    .key_size  (size_r),
    .hit       (hit)
  );

  assign mul_start = (state_r == S_DECODE) && (req_r == ffha_pkg::REQ_ARRAY);

  ffha_mul u_mul (
    .clk   (clk),
    .start (mul_start),
    .a     (size_r),
    .b     (elem_r),
    .prod  (prod)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Break growth arithmetic.
  assign limit      = end_r & ffha_pkg::ADDR_MASK;
  assign rem_w      = {1'b0, limit} - {1'b0, break_r};
  assign pad_w      = ((W+1)'(0) - first_r) & ffha_pkg::ALIGN_MASK;
  assign need_w     = {1'b0, ffha_pkg::HEADER_W} + {1'b0, pad_w} + {2'b00, size_r};
  assign grow_fit   = (need_w <= {2'b00, rem_r});
  assign new_addr_w = first_r + pad_w;

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = chk_r;
    tbl_wdata = rd_ent;
    unique case (state_r)
      S_SCAN: begin
        if (pend_r && hit) begin
          if (!find_mode_r) begin
            tbl_we         = 1'b1;
            tbl_wdata.free = 1'b0;
          end else if (!rd_ent.free && req_r == ffha_pkg::REQ_RELEASE) begin
            tbl_we         = 1'b1;
            tbl_wdata.free = 1'b1;
          end
        end
      end
      S_GROW2: begin
        tbl_we    = grow_fit;
        tbl_waddr = count_r[ffha_pkg::IDX_W-1:0];
        tbl_wdata = '{user_addr: new_addr_w[W-1:0], size: size_r, free: 1'b0};
      end
      S_FREE_OLD: begin
        tbl_we    = 1'b1;
        tbl_waddr = old_idx_r;
        tbl_wdata = '{user_addr: addr_r, size: old_size_r, free: 1'b1};
      end
      default: begin
        tbl_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      break_r     <= '0;
      end_r       <= '1;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      move_r      <= 1'b0;
      find_mode_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == ffha_pkg::CFG_HEAP_START) begin
          if (count_r == '0) begin
            break_r <= cfg_wdata & ffha_pkg::ADDR_MASK;
          end
        end else if (cfg_index == ffha_pkg::CFG_HEAP_END) begin
          end_r <= cfg_wdata;
        end
      end

      // Load a finished result, else drop a result the receiver took.
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            req_r   <= ffha_pkg::req_t'(in_req_type);
            addr_r  <= in_block_address;
            size_r  <= in_request_size;
            elem_r  <= in_element_count;
            st_r    <= ffha_pkg::ST_OK;
            res_r   <= '0;
            paddr_r <= '0;
            psize_r <= '0;
            move_r  <= 1'b0;
            state_r <= S_DECODE;
          end
        end

        S_DECODE: begin
          issue_r <= '0;
          pend_r  <= 1'b0;
          unique case (req_r)
            ffha_pkg::REQ_ALLOC: begin
              find_mode_r <= 1'b0;
              if (size_r == '0) begin
                st_r    <= ffha_pkg::ST_ZERO;
                state_r <= S_DONE;
              end else begin
                state_r <= S_SCAN;
              end
            end
            ffha_pkg::REQ_RELEASE: begin
              find_mode_r <= 1'b1;
              state_r     <= (addr_r == '0) ? S_DONE : S_SCAN;
            end
            ffha_pkg::REQ_RESIZE: begin
              if (addr_r != '0) begin
                find_mode_r <= 1'b1;
                state_r     <= S_SCAN;
              end else if (size_r == '0) begin
                // Null resize acts as allocate.
                st_r    <= ffha_pkg::ST_ZERO;
                state_r <= S_DONE;
              end else begin
                find_mode_r <= 1'b0;
                state_r     <= S_SCAN;
              end
            end
            ffha_pkg::REQ_ARRAY: begin
              find_mode_r <= 1'b0;
              state_r     <= S_MUL;
            end
          endcase
        end

        S_MUL: begin
          if (prod == '0) begin
            st_r    <= ffha_pkg::ST_ZERO;
            state_r <= S_DONE;
          end else if (prod[2*W-1:W] != '0) begin
            st_r    <= ffha_pkg::ST_EXHAUSTED;
            state_r <= S_DONE;
          end else begin
            size_r  <= prod[W-1:0];
            state_r <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (pend_r && hit) begin
            pend_r <= 1'b0;
            if (!find_mode_r) begin
              res_r   <= rd_ent.user_addr;
              state_r <= move_r ? S_FREE_OLD : S_DONE;
            end else if (rd_ent.free) begin
              st_r    <= ffha_pkg::ST_DOUBLE;
              state_r <= S_DONE;
            end else if (req_r == ffha_pkg::REQ_RELEASE) begin
              paddr_r <= addr_r;
              psize_r <= rd_ent.size;
              state_r <= S_DONE;
            end else if (size_r <= rd_ent.size) begin
              res_r   <= addr_r;
              state_r <= S_DONE;
            end else begin
              // Block too small: remember it, then scan again for a new one.
              old_idx_r   <= chk_r;
              old_size_r  <= rd_ent.size;
              move_r      <= 1'b1;
              find_mode_r <= 1'b0;
              issue_r     <= '0;
            end
          end else if (issue_r < count_r) begin
            pend_r  <= 1'b1;
            chk_r   <= issue_r[ffha_pkg::IDX_W-1:0];
            issue_r <= issue_r + 1'b1;
          end else begin
            pend_r <= 1'b0;
            if (find_mode_r) begin
              st_r    <= ffha_pkg::ST_UNKNOWN;
              state_r <= S_DONE;
            end else begin
              state_r <= S_GROW1;
            end
          end
        end

        S_GROW1: begin
          first_r <= {1'b0, break_r} + ffha_pkg::HEADER_W;
          rem_r   <= rem_w[W-1:0];
          if (count_r >= ffha_pkg::MAX_CNT) begin
            st_r    <= ffha_pkg::ST_FULL;
            state_r <= S_DONE;
          end else if (rem_w[W] || (rem_w < ffha_pkg::HEADER_W)) begin
            st_r    <= ffha_pkg::ST_EXHAUSTED;
            state_r <= S_DONE;
          end else begin
            state_r <= S_GROW2;
          end
        end

        S_GROW2: begin
          if (grow_fit) begin
            count_r <= count_r + 1'b1;
            break_r <= break_r + need_w[W-1:0];
            res_r   <= new_addr_w[W-1:0];
            state_r <= move_r ? S_FREE_OLD : S_DONE;
          end else begin
            st_r    <= ffha_pkg::ST_EXHAUSTED;
            state_r <= S_DONE;
          end
        end

        S_FREE_OLD: begin
          paddr_r <= addr_r;
          psize_r <= old_size_r;
          state_r <= S_DONE;
        end

        S_DONE: begin
          if (out_free) begin
            out_status_r <= st_r;
            out_res_r    <= (st_r == ffha_pkg::ST_OK) ? res_r : '0;
            out_paddr_r  <= (st_r == ffha_pkg::ST_OK) ? paddr_r : '0;
            out_psize_r  <= (st_r == ffha_pkg::ST_OK) ? psize_r : '0;
            state_r      <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_address = out_res_r;
  assign out_prior_address  = out_paddr_r;
  assign out_prior_size     = out_psize_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ffha_pkg::MAX_CNT)
    else $error("chunk count beyond table depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r)) || (count_r == $past(count_r) + 1'b1))
    else $error("chunk count moved by more than one");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ffha_pkg::ST_OK) |->
      (out_res_r == '0 && out_paddr_r == '0 && out_psize_r == '0))
    else $error("failed request returned nonzero fields");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside done state");

  a_free_old_move: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FREE_OLD) |-> (move_r && req_r == ffha_pkg::REQ_RESIZE))
    else $error("old block freed outside a resize move");

endmodule
